[sv/chkv_pkg.sv]
// ----------------------------------------------------------------------------
// chkv_pkg
// Shared types and constants of the chained hash key-value store.
// ----------------------------------------------------------------------------
package chkv_pkg;

    localparam int NUM_BUCKETS_DEF = 10007;
    localparam int CHAIN_DEPTH_DEF = 4;
    localparam int KEY_W = 94;
    localparam int BAL_W = 32;
    localparam int ENTRY_W = KEY_W + BAL_W;
    localparam int HASH_W = 21;
    localparam int TOTAL_W = 16;

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_DELETE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [27:0] letters;
        logic [9:0]  dig_c;
        logic [9:0]  dig_d;
        logic [3:0]  ten;
        logic [7:0]  sep;
        logic [16:0] dig_b;
        logic [16:0] dig_a;
    } key_t;

    typedef struct packed {
        key_t        key;
        logic [31:0] bal;
    } entry_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        begin
            s = {a[31], a} + {b[31], b};
            if (s[32] != s[31]) begin
                sat_add = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                sat_add = s[31:0];
            end
        end
    endfunction

endpackage

[sv/chkv_hash.sv]
// ----------------------------------------------------------------------------
// chkv_hash
// Bucket index: weighted sum of key fields (always below 2^21), reduced modulo
// NUM_BUCKETS by reciprocal multiplication and one correcting subtract.
// ----------------------------------------------------------------------------
module chkv_hash #(
    parameter int NUM_BUCKETS = chkv_pkg::NUM_BUCKETS_DEF,
    parameter int BKT_W = $clog2(NUM_BUCKETS)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  chkv_pkg::key_t     key,
    output logic               done,
    output logic [BKT_W-1:0]   bucket
);
    import chkv_pkg::*;

    localparam logic [HASH_W-1:0] MODV  = HASH_W'(NUM_BUCKETS);
    localparam logic [HASH_W-1:0] RECIP = HASH_W'((2 ** HASH_W) / NUM_BUCKETS);

    logic [HASH_W-1:0]   sq0_reg, sq1_reg, sq2_reg, sq3_reg, lin_reg;
    logic [HASH_W-1:0]   sum_reg, keep_reg, rem_reg;
    logic [2*HASH_W-1:0] prod_reg;
    logic [BKT_W-1:0]    bucket_reg;
    logic                load_reg, mul_reg, sub_reg, fix_reg, done_reg;
    logic [6:0]          l0, l1, l2, l3;
    logic [HASH_W-1:0]   quot, rem_fix;

    assign l0 = key.letters[27:21];
    assign l1 = key.letters[20:14];
    assign l2 = key.letters[13:7];
    assign l3 = key.letters[6:0];

    assign quot    = prod_reg[2*HASH_W-1:HASH_W];
    assign rem_fix = (rem_reg >= MODV) ? rem_reg - MODV : rem_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            sq0_reg <= HASH_W'(11 * l0 * l0);
            sq1_reg <= HASH_W'(13 * l1 * l1);
            sq2_reg <= HASH_W'(17 * l2 * l2);
            sq3_reg <= HASH_W'(19 * l3 * l3);
            lin_reg <= HASH_W'(2 * key.dig_a) + HASH_W'(3 * key.dig_b)
                     + HASH_W'(5 * key.dig_c) + HASH_W'(7 * key.dig_d);
        end
        if (load_reg) begin
            sum_reg <= lin_reg + sq0_reg + sq1_reg + sq2_reg + sq3_reg;
        end
        if (mul_reg) begin
            prod_reg <= (2*HASH_W)'(sum_reg) * (2*HASH_W)'(RECIP);
            keep_reg <= sum_reg;
        end
        if (sub_reg) begin
            rem_reg <= keep_reg - quot * MODV;
        end
        if (fix_reg) begin
            bucket_reg <= BKT_W'(rem_fix);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg <= 1'b0;
            mul_reg  <= 1'b0;
            sub_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            load_reg <= start;
            mul_reg  <= load_reg;
            sub_reg  <= mul_reg;
            fix_reg  <= sub_reg;
            done_reg <= fix_reg;
        end
    end

    assign done   = done_reg;
    assign bucket = bucket_reg;

endmodule

[sv/chkv_entry_mem.sv]
// ----------------------------------------------------------------------------
// chkv_entry_mem
// Entry storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module chkv_entry_mem #(
    parameter int DEPTH = 40028,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  chkv_pkg::entry_t     wdata,
    input  logic [ADDR_W-1:0]    raddr,
    output chkv_pkg::entry_t     rdata
);
    import chkv_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/chkv_len_mem.sv]
// ----------------------------------------------------------------------------
// chkv_len_mem
// Chain-length storage with a clearing pass after reset.
// ----------------------------------------------------------------------------
module chkv_len_mem #(
    parameter int DEPTH = 10007,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int LEN_W = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [LEN_W-1:0]   wdata,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [LEN_W-1:0]   rdata,
    output logic               clear_busy
);
    logic [LEN_W-1:0]  mem [DEPTH];
    logic [ADDR_W-1:0] clr_reg;
    logic              busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            clr_reg  <= '0;
        end else if (busy_reg) begin
            if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                busy_reg <= 1'b0;
            end
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[clr_reg] <= '0;
        end else if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

    assign clear_busy = busy_reg;

endmodule

[sv/chained_hash_key_value_store.sv]
// A create passes through the five hash stages, the length read, the action
// and the output register; other commands also compare the chain entries in
// turn, and a delete then shifts the later entries down. One item in
// flight; the next item can be accepted in the cycle after the previous
// result is registered, even while that result waits.
// Reset: synchronous; control clears at once, then a pass over all NUM_BUCKETS
// chain lengths zeros them, during which no item is accepted.
// ----------------------------------------------------------------------------
// chained_hash_key_value_store
// Hashed key-value table of saturating balances with ordered bucket chains.
// ----------------------------------------------------------------------------
module chained_hash_key_value_store #(
    parameter int NUM_BUCKETS = chkv_pkg::NUM_BUCKETS_DEF,
    parameter int CHAIN_DEPTH = chkv_pkg::CHAIN_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[1:0], key_letters[29:2], key_digits_c[39:30], key_digits_d[49:40],
    // key_digit_ten[53:50], key_separator[61:54], key_digits_b[78:62],
    // key_digits_a[95:79], amount[127:96]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], balance[33:2], stored_total[49:34], zero pad[55:50]
    output logic [55:0]  m_tdata
);
    import chkv_pkg::*;

    localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int DEPTH  = NUM_BUCKETS * CHAIN_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(CHAIN_DEPTH + 1);
    localparam int IDX_W  = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HASH  = 4'd1;
    localparam logic [3:0] S_LEN   = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_ACT   = 4'd5;
    localparam logic [3:0] S_SHRD  = 4'd6;
    localparam logic [3:0] S_SHWR  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_LENRD = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        cmd_reg;
    key_t              key_reg;
    logic [31:0]       amt_reg;
    logic [BKT_W-1:0]  bkt_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              hit_reg, hit_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [1:0]        st_reg, st_next;
    logic [31:0]       bal_reg, bal_next;
    logic              ov_reg;
    logic [55:0]       out_reg;
    logic              out_load;

    logic              h_done;
    logic [BKT_W-1:0]  h_bucket;
    logic              e_we;
    logic [ADDR_W-1:0] e_waddr, e_raddr;
    entry_t            e_wdata, e_rdata;
    logic              l_we;
    logic [LEN_W-1:0]  l_wdata, l_rdata;
    logic              clr_busy;
    logic [ADDR_W-1:0] base;
    key_t              in_key;

    assign in_key = '{letters: s_tdata[29:2], dig_c: s_tdata[39:30], dig_d: s_tdata[49:40],
                      ten: s_tdata[53:50], sep: s_tdata[61:54], dig_b: s_tdata[78:62],
                      dig_a: s_tdata[95:79]};
    assign base   = ADDR_W'(bkt_reg) * ADDR_W'(CHAIN_DEPTH);
    assign s_tready = (state_reg == S_IDLE) && !clr_busy;
    assign out_load = (state_reg == S_OUT) && (!ov_reg || m_tready);

    chkv_hash #(.NUM_BUCKETS(NUM_BUCKETS), .BKT_W(BKT_W)) u_hash (
        .aclk(aclk), .aresetn(aresetn), .start(s_tvalid && s_tready),
        .key(in_key), .done(h_done), .bucket(h_bucket)
    );

    chkv_entry_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_entries (
        .aclk(aclk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    chkv_len_mem #(.DEPTH(NUM_BUCKETS), .ADDR_W(BKT_W), .LEN_W(LEN_W)) u_lens (
        .aclk(aclk), .aresetn(aresetn), .we(l_we), .waddr(bkt_reg),
        .wdata(l_wdata), .raddr(bkt_reg), .rdata(l_rdata), .clear_busy(clr_busy)
    );

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        hit_next   = hit_reg;
        total_next = total_reg;
        st_next    = st_reg;
        bal_next   = bal_reg;
        e_we       = 1'b0;
        e_waddr    = base + ADDR_W'(idx_reg);
        e_wdata    = '{key: key_reg, bal: amt_reg};
        e_raddr    = base + ADDR_W'(idx_reg);
        l_we       = 1'b0;
        l_wdata    = len_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                if (h_done) begin
                    state_next = S_LENRD;
                end
            end
            S_LENRD: begin
                state_next = S_LEN;
            end
            S_LEN: begin
                idx_next = '0;
                hit_next = 1'b0;
                st_next  = ST_OK;
                bal_next = '0;
                if (cmd_reg == CMD_CREATE || l_rdata == '0) begin
                    state_next = S_ACT;
                end else begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (e_rdata.key == key_reg) begin
                    hit_next   = 1'b1;
                    state_next = S_ACT;
                end else if (LEN_W'(idx_reg) + 1'b1 >= len_reg) begin
                    state_next = S_ACT;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_ACT: begin
                state_next = S_OUT;
                if (cmd_reg == CMD_ADD && hit_reg) begin
                    bal_next = sat_add(e_rdata.bal, amt_reg);
                    e_we     = 1'b1;
                    e_wdata  = '{key: key_reg, bal: sat_add(e_rdata.bal, amt_reg)};
                end else if (cmd_reg == CMD_CREATE || cmd_reg == CMD_ADD) begin
                    if (len_reg >= LEN_W'(CHAIN_DEPTH)) begin
                        st_next = ST_FULL;
                    end else begin
                        e_we       = 1'b1;
                        e_waddr    = base + ADDR_W'(len_reg);
                        l_we       = 1'b1;
                        l_wdata    = len_reg + 1'b1;
                        total_next = total_reg + 1'b1;
                        if (cmd_reg == CMD_ADD) begin
                            bal_next = amt_reg;
                        end
                    end
                end else if (!hit_reg) begin
                    st_next = ST_NOTFOUND;
                end else if (cmd_reg == CMD_LOOKUP) begin
                    bal_next = e_rdata.bal;
                end else begin
                    l_we       = 1'b1;
                    l_wdata    = len_reg - 1'b1;
                    total_next = total_reg - 1'b1;
                    if (LEN_W'(idx_reg) + 1'b1 < len_reg) begin
                        e_raddr    = base + ADDR_W'(idx_reg) + 1'b1;
                        state_next = S_SHWR;
                    end
                end
            end
            S_SHRD: begin
                e_raddr    = base + ADDR_W'(idx_reg) + 1'b1;
                state_next = S_SHWR;
            end
            S_SHWR: begin
                e_we     = 1'b1;
                e_wdata  = e_rdata;
                idx_next = idx_reg + 1'b1;
                if ((LEN_W + 1)'(idx_reg) + (LEN_W + 1)'(2) < {1'b0, len_reg}) begin
                    state_next = S_SHRD;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
            if (out_load) begin
                ov_reg <= 1'b1;
            end else if (m_tready) begin
                ov_reg <= 1'b0;
            end
        end
        if (s_tvalid && s_tready) begin
            cmd_reg <= s_tdata[1:0];
            key_reg <= in_key;
            amt_reg <= s_tdata[127:96];
        end
        if (state_reg == S_HASH && h_done) begin
            bkt_reg <= h_bucket;
        end
        if (state_reg == S_LEN) begin
            len_reg <= (l_rdata > LEN_W'(CHAIN_DEPTH)) ? LEN_W'(CHAIN_DEPTH) : l_rdata;
        end
        if (out_load) begin
            out_reg <= {6'd0, total_reg, bal_reg, st_reg};
        end
        idx_reg <= idx_next;
        hit_reg <= hit_next;
        st_reg  <= st_next;
        bal_reg <= bal_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    a_no_accept_while_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_tready)
        else $error("item accepted during length clear");
    a_full_no_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (l_we && state_reg == S_ACT && st_next == ST_FULL) |-> 1'b0)
        else $error("length written on full bucket");
    a_total_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_ACT) |=> $stable(total_reg))
        else $error("total changed outside action");
`endif

endmodule

[tb/chained_hash_key_value_store_checker.sv]
// ----------------------------------------------------------------------------
// chained_hash_key_value_store_checker
// Watches both item channels of the key-value store, predicts each answer
// from a private copy of the bucket chains and compares it field by field.
// ----------------------------------------------------------------------------
module chained_hash_key_value_store_checker
    import chkv_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int CHAIN_DEPTH = CHAIN_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [55:0]  m_tdata,
    output int           error_count,
    output int           pending_count,
    output int           full_seen,
    output int           hit_seen,
    output int           miss_seen
);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] balance;
        logic [15:0] total;
    } answer_t;

    entry_t      chains [NUM_BUCKETS][CHAIN_DEPTH];
    int          chain_len [NUM_BUCKETS];
    logic [15:0] stored_count;
    answer_t     answers_due [$];

    function automatic int bucket_index(key_t k);
        logic [31:0] l0, l1, l2, l3, n;
        l0 = 32'(k.letters[27:21]);
        l1 = 32'(k.letters[20:14]);
        l2 = 32'(k.letters[13:7]);
        l3 = 32'(k.letters[6:0]);
        n = 2 * 32'(k.dig_a) + 3 * 32'(k.dig_b) + 5 * 32'(k.dig_c) + 7 * 32'(k.dig_d)
          + 11 * l0 * l0 + 13 * l1 * l1 + 17 * l2 * l2 + 19 * l3 * l3;
        return int'(n % NUM_BUCKETS);
    endfunction

    function automatic logic [31:0] clamp_sum(logic [31:0] a, logic [31:0] b);
        longint s;
        s = longint'($signed(a)) + longint'($signed(b));
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[31:0];
    endfunction

    function automatic answer_t apply_command(logic [127:0] d);
        logic [1:0]  cmd;
        key_t        k;
        logic [31:0] amt;
        int          z, len, hit;
        answer_t     a;
        cmd = d[1:0];
        k.letters = d[29:2];
        k.dig_c = d[39:30];
        k.dig_d = d[49:40];
        k.ten = d[53:50];
        k.sep = d[61:54];
        k.dig_b = d[78:62];
        k.dig_a = d[95:79];
        amt = d[127:96];
        a = '0;
        z = bucket_index(k);
        len = chain_len[z];
        hit = -1;
        if (cmd != CMD_CREATE) begin
            for (int i = 0; i < len; i++) begin
                if (hit < 0 && chains[z][i].key == k) hit = i;
            end
        end
        if (cmd == CMD_ADD && hit >= 0) begin
            chains[z][hit].bal = clamp_sum(chains[z][hit].bal, amt);
            a.balance = chains[z][hit].bal;
        end else if (cmd == CMD_CREATE || cmd == CMD_ADD) begin
            if (len >= CHAIN_DEPTH) begin
                a.status = ST_FULL;
            end else begin
                chains[z][len] = '{key: k, bal: amt};
                chain_len[z] = len + 1;
                stored_count++;
                if (cmd == CMD_ADD) a.balance = amt;
            end
        end else if (hit < 0) begin
            a.status = ST_NOTFOUND;
        end else if (cmd == CMD_LOOKUP) begin
            a.balance = chains[z][hit].bal;
        end else begin
            for (int i = hit; i + 1 < len; i++) chains[z][i] = chains[z][i + 1];
            chain_len[z] = len - 1;
            stored_count--;
        end
        a.total = stored_count;
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    initial begin
        error_count = 0;
        pending_count = 0;
        full_seen = 0;
        hit_seen = 0;
        miss_seen = 0;
        stored_count = '0;
        foreach (chain_len[i]) chain_len[i] = 0;
    end

    always @(posedge aclk) begin
        answer_t want, got;
        if (aresetn && s_tvalid && s_tready) begin
            want = apply_command(s_tdata);
            answers_due = {answers_due, want};
            if (want.status == ST_FULL) full_seen++;
            if (want.status == ST_NOTFOUND) miss_seen++;
            if (want.status == ST_OK && s_tdata[1:0] >= CMD_LOOKUP) hit_seen++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[1:0];
            got.balance = m_tdata[33:2];
            got.total = m_tdata[49:34];
            if (answers_due.size() == 0) begin
                report_mismatch("unexpected item", 32'(m_tdata[33:0]), '0);
            end else begin
                want = answers_due.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.balance != want.balance)
                    report_mismatch("balance", got.balance, want.balance);
                if (got.total != want.total)
                    report_mismatch("stored_total", 32'(got.total), 32'(want.total));
            end
        end
        pending_count = answers_due.size();
    end

endmodule

[tb/chained_hash_key_value_store_tb.sv]
// ----------------------------------------------------------------------------
// chained_hash_key_value_store_tb
// Drives create, add, lookup and delete items into the key-value store with
// random idling and a long output hold-off; a checker predicts every answer.
// ----------------------------------------------------------------------------
module chained_hash_key_value_store_tb;
    import chkv_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    localparam int IDLE_LIMIT = 60000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;

    int error_count, pending_count, full_seen, hit_seen, miss_seen;
    int send_idle_pct = 20;
    int recv_idle_pct = 56;
    bit hold_output = 1'b0;
    int idle_cycles = 0;
    int sent = 0;

    key_t key_pool [16];

    always #6 aclk = ~aclk;

    chained_hash_key_value_store u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    chained_hash_key_value_store_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .error_count(error_count), .pending_count(pending_count),
        .full_seen(full_seen), .hit_seen(hit_seen), .miss_seen(miss_seen)
    );

    function automatic logic [127:0] pack_item(logic [1:0] cmd, key_t k, logic [31:0] amt);
        return {amt, k.dig_a, k.dig_b, k.sep, k.ten, k.dig_d, k.dig_c, k.letters, cmd};
    endfunction

    function automatic key_t random_key();
        key_t k;
        k.letters = 28'($urandom());
        k.dig_c = 10'($urandom());
        k.dig_d = 10'($urandom());
        k.ten = 4'($urandom());
        k.sep = 8'($urandom());
        k.dig_b = 17'($urandom());
        k.dig_a = 17'($urandom());
        return k;
    endfunction

    // Same hash: shift dig_a by n*NUM_BUCKETS, keeping 2a mod N while the 17-bit field does not wrap.
    function automatic key_t collide_key(key_t k, int n);
        key_t c;
        c = k;
        c.dig_a = k.dig_a + 17'(n * NUM_BUCKETS_DEF);
        return c;
    endfunction

    task automatic send_item(logic [1:0] cmd, key_t k, logic [31:0] amt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_item(cmd, k, amt);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    always @(posedge aclk) begin
        if (hold_output) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        key_t k, base_key;
        logic [1:0] cmd;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        base_key = '0;
        base_key.dig_a = 17'd10;
        send_item(CMD_LOOKUP, base_key, 32'h1234_5678);
        send_item(CMD_DELETE, base_key, '0);
        send_item(CMD_CREATE, base_key, 32'h7FFF_FFF0);
        send_item(CMD_ADD, base_key, 32'h0000_0100);
        send_item(CMD_CREATE, base_key, 32'h0000_0005);
        send_item(CMD_LOOKUP, base_key, '0);
        send_item(CMD_ADD, base_key, 32'h8000_0000);
        send_item(CMD_ADD, base_key, 32'h8000_0000);
        send_item(CMD_ADD, collide_key(base_key, 1), 32'hFFFF_FFFF);
        send_item(CMD_CREATE, collide_key(base_key, 2), 32'h0000_0001);
        send_item(CMD_CREATE, collide_key(base_key, 3), '0);
        send_item(CMD_ADD, collide_key(base_key, 4), '0);
        send_item(CMD_DELETE, base_key, '0);
        send_item(CMD_LOOKUP, base_key, '0);
        send_item(CMD_DELETE, collide_key(base_key, 2), '0);
        send_item(CMD_LOOKUP, collide_key(base_key, 3), '0);
        k = '1;
        send_item(CMD_CREATE, k, 32'hFFFF_FFFF);
        send_item(CMD_ADD, k, 32'h7FFF_FFFF);
        send_item(CMD_LOOKUP, k, '0);
        send_item(CMD_DELETE, k, '0);

        foreach (key_pool[i]) key_pool[i] = random_key();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct = 56;
                recv_idle_pct = 20;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n == RANDOM_ITEMS / 2) begin
                fork
                    begin
                        hold_output = 1'b1;
                        repeat (800) @(posedge aclk);
                        hold_output = 1'b0;
                    end
                join_none
            end
            cmd = 2'($urandom_range(3));
            case ($urandom_range(9))
                0, 1: k = random_key();
                2, 3: k = collide_key(key_pool[0], $urandom_range(5));
                default: k = key_pool[$urandom_range(15)];
            endcase
            send_item(cmd, k, $urandom());
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0 || hold_output) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Covered %0d items: %0d full buckets, %0d hits, %0d misses on lookup/delete",
                 sent, full_seen, hit_seen, miss_seen);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
